[rtl/core/swlc_pkg.sv]
// ---------------------------------------------------------------------------
// swlc_pkg
// Shared commands, actions, register indexes and fixed sizes of the
// sliding-window link controller.
// ---------------------------------------------------------------------------
package swlc_pkg;

  // window sizes: the result fields are sized for these
  localparam int SLOTS   = 4;
  localparam int SEQ_MOD = 8;
  localparam int MAX_LEN = 64;

  typedef enum logic [2:0] {
    CMD_SEND  = 3'd0,
    CMD_ACK   = 3'd1,
    CMD_NAK   = 3'd2,
    CMD_DATA  = 3'd3,
    CMD_CKERR = 3'd4,
    CMD_DELIV = 3'd5,
    CMD_TICK  = 3'd6,
    CMD_NONE7 = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_XMIT    = 4'd1,
    ACT_ACK     = 4'd2,
    ACT_NAK     = 4'd3,
    ACT_STORE   = 4'd4,
    ACT_DELIVER = 4'd5,
    ACT_FULL    = 4'd6,
    ACT_NOTRDY  = 4'd7,
    ACT_FAILED  = 4'd8
  } act_t;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_MAXERR  = 1'b1;

endpackage

[rtl/core/sliding_window_link_controller.sv]
// ---------------------------------------------------------------------------
// sliding_window_link_controller
// Selective-repeat window controller: slot tables sit in a memory, one slot
// is read, modified and written back per cycle.
// ---------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  in      | in_command, in_number, in_length        | start & !busy
//  out     | out_action .. out_last                  | out_strobe, one cycle
//  cfg     | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// Busy stays high from start until the last result of the command has been
// shown: after an ack it also covers retiring the acknowledged slots (one
// acknowledged slot retired per cycle), after a tick it covers checking all
// slots and then sending the timed-out ones again.
// Reset clears all control state; the slot memory needs no pass.
// The receiver cannot stall: each result is shown for one cycle only.
module sliding_window_link_controller #(
  parameter int TIME_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_command,
  input  logic [3:0] in_number,
  input  logic [7:0] in_length,
  output logic       out_strobe,
  output logic [3:0] out_action,
  output logic [1:0] out_slot,
  output logic [3:0] out_seq_field,
  output logic [2:0] out_ack_field,
  output logic [6:0] out_length_out,
  output logic [7:0] out_error_total,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int SLOTS   = swlc_pkg::SLOTS;
  localparam int SEQ_MOD = swlc_pkg::SEQ_MOD;
  localparam int MAX_LEN = swlc_pkg::MAX_LEN;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = $clog2(SEQ_MOD);
  localparam int FW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WORK = 6'b000010,
    ST_ACKW = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // slot memory: sent time, sequence, out length, in length
  typedef struct packed {
    logic [TIME_BITS-1:0] sent;
    logic [QW-1:0]        seq;
    logic [6:0]           olen;
    logic [6:0]           ilen;
  } ent_t;

  ent_t mem [SLOTS];
  ent_t rd_r;
  logic           we;
  logic [SW-1:0]  waddr, raddr;
  ent_t           wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  state_t st_r, st_nxt;
  logic [2:0] cmd_r;
  logic [3:0] num_r;
  logic [6:0] len_r;
  logic [7:0] tmo_r, maxe_r, err_r, err_nxt;
  logic [QW-1:0] slo_r, slo_nxt, snx_r, snx_nxt, rlo_r, rlo_nxt, rhi_r, rhi_nxt;
  logic [FW-1:0] fl_r, fl_nxt;
  logic nak_r, nak_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [SLOTS-1:0] pend_r, pend_nxt, arr_r, arr_nxt;
  logic [SLOTS-1:0] hit_r, hit_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic phase_r, phase_nxt;

  // result register
  logic o_stb_nxt, o_last_nxt;
  logic [3:0] o_act_nxt, o_seq_nxt;
  logic [1:0] o_slot_nxt;
  logic [2:0] o_ack_nxt;
  logic [6:0] o_len_nxt;

  function automatic logic in_win(logic [QW-1:0] lo, logic [QW-1:0] x, logic [QW-1:0] hi);
    return (lo <= x && x < hi) || (hi < lo && lo <= x) || (x < hi && hi < lo);
  endfunction

  function automatic logic [QW-1:0] inc(logic [QW-1:0] v);
    logic [QW:0] t;
    t = {1'b0, v} + 1'b1;
    return (t == (QW+1)'(SEQ_MOD)) ? '0 : t[QW-1:0];
  endfunction

  function automatic logic [6:0] clamp(logic [7:0] v);
    return (v > 8'(MAX_LEN)) ? 7'(MAX_LEN) : v[6:0];
  endfunction

  function automatic logic [7:0] sat(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [SW-1:0] smod(logic [QW-1:0] v);
    return SW'(v % SLOTS);
  endfunction

  assign busy      = (st_r != ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE) && !start;

  logic num_ok;
  logic [QW-1:0] num_q;
  assign num_ok = ({28'd0, num_r} < 32'(SEQ_MOD));
  assign num_q  = num_r[QW-1:0];

  always_comb begin
    st_nxt = st_r; slo_nxt = slo_r; snx_nxt = snx_r; rlo_nxt = rlo_r; rhi_nxt = rhi_r;
    fl_nxt = fl_r; err_nxt = err_r; nak_nxt = nak_r; now_nxt = now_r;
    pend_nxt = pend_r; arr_nxt = arr_r; hit_nxt = hit_r; idx_nxt = idx_r;
    cnt_nxt = cnt_r; phase_nxt = phase_r;
    we = 1'b0; waddr = idx_r; wdata = rd_r; raddr = idx_r;
    o_stb_nxt = 1'b0; o_last_nxt = 1'b0; o_act_nxt = swlc_pkg::ACT_NONE;
    o_slot_nxt = '0; o_seq_nxt = '0; o_ack_nxt = '0; o_len_nxt = '0;
    unique case (st_r)
      ST_IDLE: begin
        raddr = smod(in_number[QW-1:0]);
        if (start) begin
          idx_nxt = '0; cnt_nxt = '0; phase_nxt = 1'b0; hit_nxt = '0;
          unique case (swlc_pkg::cmd_t'(in_command))
            swlc_pkg::CMD_SEND:  idx_nxt = smod(snx_r);
            swlc_pkg::CMD_NAK,
            swlc_pkg::CMD_DATA:  idx_nxt = smod(in_number[QW-1:0]);
            swlc_pkg::CMD_DELIV: idx_nxt = smod(rlo_r);
            default:             idx_nxt = '0;
          endcase
          raddr = idx_nxt;
          if (swlc_pkg::cmd_t'(in_command) == swlc_pkg::CMD_TICK && err_r < maxe_r) begin
            now_nxt = now_r + 1'b1;
            st_nxt  = ST_SCAN;
          end else if (swlc_pkg::cmd_t'(in_command) == swlc_pkg::CMD_ACK) begin
            st_nxt = ST_ACKW;
          end else begin
            st_nxt = ST_WORK;
          end
        end
      end
      ST_ACKW: begin
        // retire one acknowledged slot per cycle
        if (err_r >= maxe_r) begin
          st_nxt = ST_WORK;
        end else if (num_ok && in_win(slo_r, num_q, snx_r)) begin
          if (fl_r != '0) fl_nxt = fl_r - 1'b1;
          pend_nxt[smod(slo_r)] = 1'b0;
          slo_nxt = inc(slo_r);
        end else begin
          o_stb_nxt = 1'b1; o_last_nxt = 1'b1; st_nxt = ST_DONE;
        end
      end
      ST_WORK: begin
        o_stb_nxt = 1'b1; o_last_nxt = 1'b1;
        st_nxt = ST_DONE;
        if (err_r >= maxe_r) begin
          o_act_nxt = swlc_pkg::ACT_FAILED;
        end else begin
          unique case (swlc_pkg::cmd_t'(cmd_r))
            swlc_pkg::CMD_SEND: begin
              if ({{(32-FW){1'b0}}, fl_r} >= 32'(SLOTS)) begin
                o_act_nxt = swlc_pkg::ACT_FULL;
              end else begin
                we = 1'b1;
                wdata.sent = now_r; wdata.seq = snx_r; wdata.olen = len_r;
                pend_nxt[idx_r] = 1'b1;
                fl_nxt = fl_r + 1'b1; snx_nxt = inc(snx_r);
                o_act_nxt = swlc_pkg::ACT_XMIT; o_slot_nxt = 2'(idx_r);
                o_seq_nxt = 4'(snx_r); o_ack_nxt = 3'(rlo_r); o_len_nxt = len_r;
              end
            end
            swlc_pkg::CMD_NAK: begin
              if (num_ok && in_win(slo_r, num_q, snx_r)) begin
                we = 1'b1; wdata.sent = now_r; wdata.seq = num_q;
                err_nxt = sat(err_r);
                o_act_nxt = swlc_pkg::ACT_XMIT; o_slot_nxt = 2'(idx_r);
                o_seq_nxt = 4'(num_q); o_ack_nxt = 3'(rlo_r); o_len_nxt = rd_r.olen;
              end
            end
            swlc_pkg::CMD_DATA: begin
              err_nxt = (num_r != 4'(rlo_r) && nak_r) ? sat(err_r) : err_r;
              if (num_ok && in_win(rlo_r, num_q, rhi_r) && !arr_r[idx_r]) begin
                we = 1'b1; wdata.ilen = len_r;
                arr_nxt[idx_r] = 1'b1;
                o_act_nxt = swlc_pkg::ACT_STORE; o_slot_nxt = 2'(idx_r); o_len_nxt = len_r;
              end
            end
            swlc_pkg::CMD_CKERR: begin
              err_nxt = sat(err_r);
              if (nak_r) begin
                nak_nxt = 1'b0; o_act_nxt = swlc_pkg::ACT_NAK; o_ack_nxt = 3'(rlo_r);
              end
            end
            swlc_pkg::CMD_DELIV: begin
              if (!arr_r[idx_r]) begin
                o_act_nxt = swlc_pkg::ACT_NOTRDY;
              end else if (!phase_r) begin
                o_act_nxt = swlc_pkg::ACT_ACK; o_ack_nxt = 3'(rlo_r);
                o_last_nxt = 1'b0; phase_nxt = 1'b1; st_nxt = ST_WORK;
              end else begin
                o_act_nxt = swlc_pkg::ACT_DELIVER; o_slot_nxt = 2'(idx_r);
                o_len_nxt = rd_r.ilen;
                nak_nxt = 1'b1; arr_nxt[idx_r] = 1'b0;
                rlo_nxt = inc(rlo_r); rhi_nxt = inc(rhi_r);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // check one slot per cycle for a timeout; rd_r holds slot idx_r
        raddr = idx_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (pend_r[idx_r] && (TIME_BITS'(now_r - rd_r.sent) >= TIME_BITS'(tmo_r))
            && cnt_r < 3'd4) begin
          we = 1'b1; wdata.sent = now_r;
          err_nxt = sat(err_r);
          cnt_nxt = cnt_r + 1'b1;
          hit_nxt[idx_r] = 1'b1;
        end
        if (idx_r == SW'(SLOTS - 1)) begin
          raddr = '0; idx_nxt = '0;
          if (hit_nxt == '0) begin
            o_stb_nxt = 1'b1; o_last_nxt = 1'b1; st_nxt = ST_DONE;
          end else begin
            st_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // send the timed-out slots again, lowest first; rd_r holds slot idx_r
        raddr = idx_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (hit_r[idx_r]) begin
          hit_nxt[idx_r] = 1'b0;
          o_stb_nxt = 1'b1; o_act_nxt = swlc_pkg::ACT_XMIT;
          o_slot_nxt = 2'(idx_r); o_seq_nxt = 4'(rd_r.seq);
          o_ack_nxt = 3'(rlo_r); o_len_nxt = rd_r.olen;
          if (hit_nxt == '0) begin
            o_last_nxt = 1'b1; st_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // final beat is on the outputs; take the next command after it
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; tmo_r <= 8'd10; maxe_r <= 8'd20; err_r <= '0;
      slo_r <= '0; snx_r <= '0; rlo_r <= '0; rhi_r <= QW'(SLOTS % SEQ_MOD);
      fl_r <= '0; nak_r <= 1'b1; now_r <= '0; pend_r <= '0; arr_r <= '0;
      hit_r <= '0; idx_r <= '0; cnt_r <= '0; phase_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      st_r <= st_nxt; err_r <= err_nxt; slo_r <= slo_nxt; snx_r <= snx_nxt;
      rlo_r <= rlo_nxt; rhi_r <= rhi_nxt; fl_r <= fl_nxt; nak_r <= nak_nxt;
      now_r <= now_nxt; pend_r <= pend_nxt; arr_r <= arr_nxt; hit_r <= hit_nxt;
      idx_r <= idx_nxt; cnt_r <= cnt_nxt; phase_r <= phase_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == swlc_pkg::CFG_TIMEOUT) tmo_r <= cfg_data;
        else maxe_r <= cfg_data;
      end
      out_strobe <= o_stb_nxt;
    end
  end

  // payload registers; the error total is the count after the whole command
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      cmd_r <= in_command; num_r <= in_number; len_r <= clamp(in_length);
    end
    if (o_stb_nxt) begin
      out_action <= o_act_nxt; out_slot <= o_slot_nxt; out_seq_field <= o_seq_nxt;
      out_ack_field <= o_ack_nxt; out_length_out <= o_len_nxt; out_last <= o_last_nxt;
      out_error_total <= err_nxt;
    end
  end

endmodule
